// ===== sv/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared types for the palindromic substring counter
// Word formats, the link between neighboring cells and the pipeline tag.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int SYMBOL_W = 8;
    localparam int TOTAL_W  = 12;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } psc_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               too_long;
    } psc_result_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic occ;
        logic mark;
    } psc_link_t;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic                step;
        logic                clear;
        logic [SYMBOL_W-1:0] symbol;
    } psc_bcast_t;

    // Sideband that travels alongside the count tree.
    typedef struct packed {
        logic last;
        logic too_long;
    } psc_tag_t;

endpackage

// ===== sv/psc_cell.sv =====
// ----------------------------------------------------------------------------
// psc_cell: one start position of the string
// Holds one stored byte, an occupied bit and the palindrome mark for the
// substring that starts here and ends at the newest byte.
// ----------------------------------------------------------------------------
module psc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  psc_pkg::psc_bcast_t bcast,
    input  psc_pkg::psc_link_t  left,
    input  psc_pkg::psc_link_t  right,
    output psc_pkg::psc_link_t  link,
    output logic                hit
);
    import psc_pkg::*;

    logic                occ_reg;
    logic                mark_reg;
    logic [SYMBOL_W-1:0] byte_reg;
    logic                write;
    logic                newest;
    logic                match;

    // The first free cell after an occupied one takes the new byte.
    assign write  = !occ_reg && left.occ;
    assign newest = occ_reg && !right.occ;
    assign match  = occ_reg && (byte_reg == bcast.symbol) && (newest || right.mark);
    assign hit    = bcast.step && (write || match);

    assign link.occ  = occ_reg;
    assign link.mark = mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            mark_reg <= 1'b0;
        end
        else if (bcast.clear)
        begin
            occ_reg  <= 1'b0;
            mark_reg <= 1'b0;
        end
        else if (bcast.step)
        begin
            occ_reg  <= occ_reg || write;
            mark_reg <= write || match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bcast.step && write)
        begin
            byte_reg <= bcast.symbol;
        end
    end

endmodule

// ===== sv/psc_count_tree.sv =====
// ----------------------------------------------------------------------------
// psc_count_tree: pipelined population count of the cell hits
// A binary tree with a register at every level, with a tag pipe beside it.
// ----------------------------------------------------------------------------
module psc_count_tree #(
    parameter int MAX_LEN = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [MAX_LEN-1:0]         hits,
    input  psc_pkg::psc_tag_t          tag_in,
    output logic [$clog2(MAX_LEN+1)-1:0] root,
    output psc_pkg::psc_tag_t          tag_out
);
    import psc_pkg::*;

    localparam int LVL = $clog2(MAX_LEN);
    localparam int P   = 1 << LVL;
    localparam int CW  = $clog2(MAX_LEN+1);

    logic [P-1:0]  leaf;
    logic [CW-1:0] node_reg [P-1];
    psc_tag_t      tag_reg  [LVL];

    assign leaf = P'(hits);

    // Heap numbering: node n sits at index n-1, its children are 2n and 2n+1.
    for (genvar n = 1; n < P; n++)
    begin : g_node
        if (n >= P/2)
        begin : g_bottom
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    node_reg[n-1] <= '0;
                end
                else if (en)
                begin
                    node_reg[n-1] <= CW'(leaf[2*n-P]) + CW'(leaf[2*n-P+1]);
                end
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    node_reg[n-1] <= '0;
                end
                else if (en)
                begin
                    node_reg[n-1] <= node_reg[2*n-1] + node_reg[2*n];
                end
            end
        end
    end

    for (genvar k = 0; k < LVL; k++)
    begin : g_tag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                if (k == 0)
                begin
                    tag_reg[k] <= tag_in;
                end
                else
                begin
                    tag_reg[k] <= tag_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign root    = node_reg[0];
    assign tag_out = tag_reg[LVL-1];

endmodule

// ===== sv/palindromic_substring_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while no result waits, set by the row of
// cells that all compare their stored byte with the new byte in the same cycle.
// The count for the last word passes through the registered count tree and
// then the result register.
// Reset clears all marks, the length, the total and the overflow flag at once.
// ----------------------------------------------------------------------------
// palindromic_substring_counter_unit: palindromic substring counter
// Counts the palindromic substrings of a string that arrives one byte a word.
// ----------------------------------------------------------------------------
module palindromic_substring_counter_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  psc_pkg::psc_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output psc_pkg::psc_result_t result
);
    import psc_pkg::*;

    localparam int CW = $clog2(MAX_LEN+1);

    logic               adv;
    logic               fire;
    logic               full;
    logic               ovf_reg;
    psc_bcast_t         bcast;
    psc_link_t          link [MAX_LEN];
    logic [MAX_LEN-1:0] hits;
    logic [MAX_LEN-1:0] occ_vec;
    psc_tag_t           tag_in;
    psc_tag_t           tag_out;
    logic [CW-1:0]      root;
    logic [TOTAL_W-1:0] acc_reg;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] sum_sat;
    logic               result_valid_reg;
    psc_result_t        result_reg;

    // The whole datapath moves together; it halts only while a result waits.
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;
    assign fire       = item_valid && adv;
    assign full       = link[MAX_LEN-1].occ;

    assign bcast.step   = fire && !full;
    assign bcast.clear  = fire && item.last;
    assign bcast.symbol = item.symbol;

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        psc_link_t left_link;
        psc_link_t right_link;

        if (i == 0)
        begin : g_head
            assign left_link = '{occ: 1'b1, mark: 1'b0};
        end
        else
        begin : g_mid_left
            assign left_link = link[i-1];
        end

        if (i == MAX_LEN-1)
        begin : g_tail
            assign right_link = '{occ: 1'b0, mark: 1'b0};
        end
        else
        begin : g_mid_right
            assign right_link = link[i+1];
        end

        psc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .bcast (bcast),
            .left  (left_link),
            .right (right_link),
            .link  (link[i]),
            .hit   (hits[i])
        );

        assign occ_vec[i] = link[i].occ;
    end

    assign tag_in.last     = fire && item.last;
    assign tag_in.too_long = ovf_reg || (fire && full);

    psc_count_tree #(
        .MAX_LEN (MAX_LEN)
    ) u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .hits    (hits),
        .tag_in  (tag_in),
        .root    (root),
        .tag_out (tag_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                ovf_reg <= 1'b0;
            end
            else if (full)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign sum_wide = {1'b0, acc_reg} + (TOTAL_W+1)'(root);
    assign sum_sat  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (tag_out.last)
            begin
                acc_reg          <= '0;
                result_valid_reg <= 1'b1;
            end
            else
            begin
                acc_reg          <= sum_sat;
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tag_out.last)
        begin
            result_reg.total    <= sum_sat;
            result_reg.too_long <= tag_out.too_long;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // Occupied cells always form one run starting at cell zero.
    a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + MAX_LEN'(1)) & occ_vec) == '0)
        else $error("cell occupancy is not contiguous");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last |=> occ_vec == '0)
        else $error("cells not cleared after the last word");

    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.last && !full |=>
        $countones(occ_vec) == $past($countones(occ_vec)) + 1)
        else $error("stored length did not grow by one");

    a_stall_holds_acc: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(acc_reg) && $stable(occ_vec))
        else $error("state moved while the result was stalled");
`endif

endmodule

// ===== sim/psc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_checker: result checker for the palindromic substring counter
// Watches both channels and keeps its own copy of the string state. Each
// accepted result word is checked, field by field, against the oldest total
// predicted from the accepted input words.
// ----------------------------------------------------------------------------
module psc_checker #(
    parameter int MAX_LEN = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  psc_pkg::psc_item_t   item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  psc_pkg::psc_result_t result,
    output int                   mismatches,
    output int                   pending,
    output int                   results_checked
);
    import psc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [SYMBOL_W-1:0] text [MAX_LEN];
    // Bit i is set when text[i] up to the newest byte reads the same both ways.
    logic [MAX_LEN-1:0]  pal_start;
    int                  text_len;
    logic [TOTAL_W-1:0]  pal_total;
    logic                dropped;
    psc_result_t         totals_q[$];

    task automatic clear_string();
        pal_start = '0;
        text_len  = 0;
        pal_total = '0;
        dropped   = 1'b0;
    endtask

    task automatic absorb_symbol(input logic [SYMBOL_W-1:0] c);
        int   added;
        int   sum;
        int   i;
        logic hit;
        if (text_len >= MAX_LEN) begin
            dropped = 1'b1;
        end else begin
            added = 1;
            // Going upward, bit i+1 still holds the previous word's mark when read.
            for (i = 0; i < text_len; i++) begin
                hit = (text[i] == c) && ((text_len - i == 1) || pal_start[i + 1]);
                pal_start[i] = hit;
                if (hit)
                    added++;
            end
            pal_start[text_len] = 1'b1;
            text[text_len] = c;
            text_len++;
            sum = int'(pal_total) + added;
            pal_total = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
        end
    endtask

    task automatic flag_field(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("psc_checker: %s mismatch at %0t: expected %0d, got %0d",
                     field, $realtime, want, got);
    endtask

    initial begin
        clear_string();
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
    end

    always @(posedge clk or negedge rst_n) begin : monitor
        psc_result_t want;
        if (!rst_n) begin
            clear_string();
            totals_q.delete();
            pending = 0;
        end else begin
            if (result_valid && result_ready) begin
                results_checked++;
                if (totals_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("psc_checker: unexpected result word at %0t: total %0d, too_long %0b",
                                 $realtime, result.total, result.too_long);
                end else begin
                    want = totals_q.pop_front();
                    if (result.total !== want.total)
                        flag_field("total", int'(want.total), int'(result.total));
                    if (result.too_long !== want.too_long)
                        flag_field("too_long", int'(want.too_long), int'(result.too_long));
                end
            end
            if (item_valid && item_ready) begin
                absorb_symbol(item.symbol);
                if (item.last) begin
                    want.total    = pal_total;
                    want.too_long = dropped;
                    totals_q.push_back(want);
                    clear_string();
                end
            end
            pending = totals_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the palindromic substring counter
// Streams directed and random strings into the counter with random idles on
// both channels, a long output stall and full-rate stretches; the checker
// beside the block predicts every total and reports mismatches.
// ----------------------------------------------------------------------------
module tb;
    import psc_pkg::*;

    localparam int MAX_LEN        = 64;
    localparam int RANDOM_ITEMS   = 280;
    localparam int MIN_RESULTS    = 40;
    localparam int HOLD_CYCLES    = 250;
    localparam int BURST_STRINGS  = 60;
    localparam int SETTLE_CYCLES  = $clog2(MAX_LEN) + 4;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef logic [SYMBOL_W-1:0] text_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    psc_item_t   item;
    logic        result_valid;
    logic        result_ready;
    psc_result_t result;

    int mismatches;
    int pending;
    int results_checked;
    int quiet_cycles;
    int items_sent;
    int strings_sent;
    int overlong_strings;
    bit no_idle;
    bit hold_req;

    logic [SYMBOL_W-1:0] alphabet [3];

    palindromic_substring_counter_unit #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    psc_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .mismatches(mismatches),
        .pending(pending),
        .results_checked(results_checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Ends the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: random stalls per word, plus one long stall on request.
    initial
    begin : receiver
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
            @(negedge clk);
        end
    end

    task automatic send_word(input logic [SYMBOL_W-1:0] sym, input logic fin);
        psc_item_t w;
        int        gap;
        w.symbol = sym;
        w.last   = fin;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do @(posedge clk); while (!(item_valid && item_ready));
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_string(input text_q_t s);
        foreach (s[k])
            send_word(s[k], k == s.size() - 1);
        strings_sent++;
        if (s.size() > MAX_LEN)
            overlong_strings++;
    endtask

    // Stop offering words until every predicted total has come back.
    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [SYMBOL_W-1:0] from_alphabet(input int span);
        return alphabet[$urandom_range(0, span - 1)];
    endfunction

    initial
    begin : stimulus
        text_q_t s;
        int      kind;
        int      len;
        int      half;
        int      span;
        int      k;
        int      random_start;
        bit      burst_done;
        logic [SYMBOL_W-1:0] fill;

        rst_n            = 1'b0;
        item_valid       = 1'b0;
        item             = '0;
        no_idle          = 1'b0;
        hold_req         = 1'b0;
        quiet_cycles     = 0;
        items_sent       = 0;
        strings_sent     = 0;
        overlong_strings = 0;
        burst_done       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings: lone bytes at both extremes, runs, odd and even mirrors.
        s = '{8'h00};                      send_string(s);
        s = '{8'hFF};                      send_string(s);
        s = '{8'hFF, 8'hFF};               send_string(s);
        s = '{8'h61, 8'h62, 8'h61};        send_string(s);
        s = '{8'h61, 8'h61, 8'h61, 8'h61}; send_string(s);
        s = '{8'h61, 8'h62};               send_string(s);
        s = '{8'h61, 8'h62, 8'h62, 8'h61}; send_string(s);
        s = '{8'h55, 8'hAA, 8'h55, 8'hAA}; send_string(s);
        drain();

        // Exactly full at full rate, then strings that run past the length limit.
        fill = SYMBOL_W'($urandom_range(0, 255));
        no_idle = 1'b1;
        s.delete();
        repeat (MAX_LEN) s.push_back(fill);
        send_string(s);
        no_idle = 1'b0;
        s.delete();
        repeat (MAX_LEN + 2) s.push_back(fill);
        send_string(s);
        s.delete();
        repeat (MAX_LEN + 6) s.push_back(SYMBOL_W'($urandom_range(0, 255)));
        send_string(s);
        drain();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS || results_checked < MIN_RESULTS)
        begin
            if (!burst_done && items_sent - random_start >= 150)
            begin
                // Hold the output off while one-byte strings arrive back to back.
                drain();
                no_idle  = 1'b1;
                hold_req = 1'b1;
                repeat (BURST_STRINGS)
                begin
                    s.delete();
                    s.push_back(SYMBOL_W'($urandom_range(0, 255)));
                    send_string(s);
                end
                no_idle = 1'b0;
                drain();
                burst_done = 1'b1;
            end

            no_idle = ((strings_sent % 30) >= 24);
            alphabet[0] = SYMBOL_W'($urandom_range(0, 255));
            alphabet[1] = alphabet[0] ^ (8'h01 << $urandom_range(0, 7));
            alphabet[2] = SYMBOL_W'($urandom_range(0, 255));
            s.delete();
            kind = $urandom_range(0, 19);
            if (kind < 10)
            begin
                len  = $urandom_range(1, 12);
                span = $urandom_range(1, 3);
                repeat (len) s.push_back(from_alphabet(span));
            end
            else if (kind < 15)
            begin
                half = $urandom_range(1, 8);
                span = $urandom_range(2, 3);
                repeat (half) s.push_back(from_alphabet(span));
                if ($urandom_range(0, 1) != 0)
                    s.push_back(from_alphabet(span));
                for (k = half - 1; k >= 0; k--)
                    s.push_back(s[k]);
            end
            else if (kind < 18)
            begin
                len = $urandom_range(1, 20);
                repeat (len) s.push_back(SYMBOL_W'($urandom_range(0, 255)));
            end
            else if (kind == 18)
            begin
                len  = $urandom_range(30, MAX_LEN);
                span = $urandom_range(1, 2);
                repeat (len) s.push_back(from_alphabet(span));
            end
            else
            begin
                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
                repeat (len) s.push_back(SYMBOL_W'($urandom_range(0, 255)));
            end
            send_string(s);
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        no_idle = 1'b0;
        drain();
        $display("tb: %0d strings, %0d bytes, %0d strings past the %0d-byte limit",
                 strings_sent, items_sent, overlong_strings, MAX_LEN);
        $display("tb: %0d totals checked; edge strings, full-rate runs, a %0d-cycle stall",
                 results_checked, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/psc_pkg.sv
sv/psc_cell.sv
sv/psc_count_tree.sv
sv/palindromic_substring_counter_unit.sv
sim/psc_checker.sv
sim/tb.sv
